@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; synthesis builds define SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/cmf_pkg.sv @@
// Package for the chroma median filter: sizes, register codes, lane tag, FSM states.
// No dependencies.
package cmf_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 3;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_BITS = 8;
  localparam int RING_ROWS   = 2 * MAX_RADIUS + 2;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int RING_W      = $clog2(RING_ROWS);
  localparam int ADDR_W      = RING_W + COL_W;
  localparam int CNT_W       = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int BIT_W       = $clog2(SAMPLE_BITS);

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [BIT_W-1:0] bitsel;
  } cmf_tag_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_FLUSH, ST_OUT} cmf_state_t;

  // rank of the median in a window of side 2r+1
  function automatic logic [CNT_W-1:0] med_rank(input logic [1:0] r);
    logic [3:0] s;
    logic [7:0] sq;
    s  = {r, 1'b1};
    sq = 8'(s * s);
    return CNT_W'(sq >> 1);
  endfunction
endpackage

@@ hdl/chroma_median_filter_top.sv @@
// Chroma median filter, edge replicate, U and V lanes side by side.
// An item with no result leaves the block ready for the next item. An item with
// a result takes eight bitwise selection passes over the window through one row
// store read port. The output register lets the next item in while a result waits.
// rst_n (synchronous) clears counters, FSM and output valid; row store has no clear.
module chroma_median_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // u_in, v_in
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // u_out, v_out
  output logic        out_tlast, // frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int CW = cmf_pkg::COL_W;
  localparam int RW = cmf_pkg::ROW_W;

  logic [1:0]  rad_r;
  logic [10:0] wid_r;
  logic [12:0] hgt_r;
  logic [10:0] eff_w, wm1;
  logic [12:0] eff_h, hm1;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt, win_col_r;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt, win_row_r;
  logic          drain_r, drain_nxt, last_r;

  cmf_pkg::cmf_state_t state_r, state_nxt;
  logic [2:0] pass_r, wi_r, wj_r;

  // configuration port
  logic cfg_wr, cfg_restart;
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_restart = cfg_wr && (cfg_paddr[3:2] == cmf_pkg::REG_RADIUS ||
                                  cfg_paddr[3:2] == cmf_pkg::REG_WIDTH ||
                                  cfg_paddr[3:2] == cmf_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= 2'd1;
      wid_r <= 11'd640;
      hgt_r <= 13'd480;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        cmf_pkg::REG_RADIUS: rad_r <= cfg_pwdata[1:0];
        cmf_pkg::REG_WIDTH:  wid_r <= cfg_pwdata[10:0];
        cmf_pkg::REG_HEIGHT: hgt_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      cmf_pkg::REG_RADIUS: cfg_prdata = {30'd0, rad_r};
      cmf_pkg::REG_WIDTH:  cfg_prdata = {21'd0, wid_r};
      cmf_pkg::REG_HEIGHT: cfg_prdata = {19'd0, hgt_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (wid_r == '0) eff_w = 11'd1;
    else if (wid_r > 11'(cmf_pkg::MAX_WIDTH)) eff_w = 11'(cmf_pkg::MAX_WIDTH);
    else eff_w = wid_r;
    if (hgt_r == '0) eff_h = 13'd1;
    else if (hgt_r > 13'(cmf_pkg::MAX_HEIGHT)) eff_h = 13'(cmf_pkg::MAX_HEIGHT);
    else eff_h = hgt_r;
    wm1 = eff_w - 11'd1;
    hm1 = eff_h - 13'd1;
  end

  // request decode
  logic acc, pix, drn, rst_frame, emit_p, emit, in_last, out_last;
  logic [CW-1:0] c0, oc0;
  logic [RW-1:0] r0, or0;
  logic [23:0]   idx_v, dly_v;

  always_comb begin
    acc       = in_tvalid && in_tready;
    pix       = acc && !in_tuser && !drain_r;
    drn       = acc && in_tuser && drain_r;
    rst_frame = ({1'b0, in_col_r} >= eff_w) || ({1'b0, in_row_r} >= eff_h);
    c0        = (pix && rst_frame) ? '0 : in_col_r;
    r0        = (pix && rst_frame) ? '0 : in_row_r;
    oc0       = (pix && rst_frame) ? '0 : out_col_r;
    or0       = (pix && rst_frame) ? '0 : out_row_r;
    // pixel index reached r*W + r
    idx_v     = 24'(r0) * 24'(eff_w) + 24'(c0);
    dly_v     = 24'(rad_r) * 24'(eff_w) + 24'(rad_r);
    emit_p    = idx_v >= dly_v;
    emit      = drn || (pix && emit_p);
    in_last   = ({1'b0, r0} == hm1) && ({1'b0, c0} == wm1);
    out_last  = ({1'b0, or0} == hm1) && ({1'b0, oc0} == wm1);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    drain_nxt   = drain_r;
    if (cfg_restart || (emit && out_last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      drain_nxt   = 1'b0;
    end else if (pix || drn) begin
      if (pix) begin
        if ({1'b0, c0} >= wm1) begin
          in_col_nxt = '0;
          in_row_nxt = r0 + RW'(1);
        end else begin
          in_col_nxt = c0 + CW'(1);
          in_row_nxt = r0;
        end
        if (in_last) drain_nxt = 1'b1;
      end
      out_col_nxt = oc0;
      out_row_nxt = or0;
      if (emit) begin
        if ({1'b0, oc0} >= wm1) begin
          out_col_nxt = '0;
          out_row_nxt = or0 + RW'(1);
        end else begin
          out_col_nxt = oc0 + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      drain_r   <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      drain_r   <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      win_col_r <= oc0;
      win_row_r <= or0;
      last_r    <= out_last;
    end
  end

  // window read sequencer
  logic [2:0] side_m1;
  logic       j_end, i_end, rd_en, done_issue, slot_free, load;
  logic signed [RW+1:0] ii;
  logic signed [CW+1:0] jj;
  logic [RW-1:0] rr;
  logic [CW-1:0] cc;
  cmf_pkg::cmf_tag_t tag_c, tag_r;

  always_comb begin
    side_m1    = {rad_r, 1'b0};
    j_end      = wj_r == side_m1;
    i_end      = wi_r == side_m1;
    done_issue = i_end && j_end && pass_r == 3'd7;
    ii = $signed({2'b00, win_row_r}) + $signed({{(RW-1){1'b0}}, wi_r})
         - $signed({{RW{1'b0}}, rad_r});
    jj = $signed({2'b00, win_col_r}) + $signed({{(CW-1){1'b0}}, wj_r})
         - $signed({{CW{1'b0}}, rad_r});
    if (ii < 0) rr = '0;
    else if (ii >= $signed({1'b0, eff_h})) rr = hm1[RW-1:0];
    else rr = ii[RW-1:0];
    if (jj < 0) cc = '0;
    else if (jj >= $signed({1'b0, eff_w})) cc = wm1[CW-1:0];
    else cc = jj[CW-1:0];
    tag_c.valid  = rd_en;
    tag_c.first  = wi_r == 3'd0 && wj_r == 3'd0;
    tag_c.last   = i_end && j_end;
    tag_c.bitsel = ~pass_r;
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      pass_r <= '0;
      wi_r   <= '0;
      wj_r   <= '0;
    end else if (rd_en) begin
      if (j_end) begin
        wj_r <= '0;
        if (i_end) begin
          wi_r   <= '0;
          pass_r <= pass_r + 3'd1;
        end else begin
          wi_r <= wi_r + 3'd1;
        end
      end else begin
        wj_r <= wj_r + 3'd1;
      end
    end
  end

  // row store: U in low byte, V in high byte
  logic [15:0] mem [cmf_pkg::RING_ROWS * cmf_pkg::MAX_WIDTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (pix) mem[{r0[cmf_pkg::RING_W-1:0], c0}] <= in_tdata;
    if (rd_en) rd_data_r <= mem[{rr[cmf_pkg::RING_W-1:0], cc}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag_r <= '0;
    else        tag_r <= tag_c;
  end

  // FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmf_pkg::ST_IDLE:  if (acc && emit) state_nxt = cmf_pkg::ST_READ;
      cmf_pkg::ST_READ:  if (done_issue) state_nxt = cmf_pkg::ST_FLUSH;
      cmf_pkg::ST_FLUSH: state_nxt = cmf_pkg::ST_OUT;
      cmf_pkg::ST_OUT:   if (slot_free) state_nxt = cmf_pkg::ST_IDLE;
      default:           state_nxt = cmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = state_r == cmf_pkg::ST_IDLE;
    rd_en     = state_r == cmf_pkg::ST_READ;
    load      = state_r == cmf_pkg::ST_OUT && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cmf_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  logic [cmf_pkg::SAMPLE_BITS-1:0] u_med, v_med;
  logic [cmf_pkg::CNT_W-1:0] rank;
  assign rank = cmf_pkg::med_rank(rad_r);

  cmf_lane u_lane_u (
    .clk(clk), .start(acc && emit), .rank(rank), .tag(tag_r),
    .sample(rd_data_r[7:0]), .median(u_med)
  );

  cmf_lane u_lane_v (
    .clk(clk), .start(acc && emit), .rank(rank), .tag(tag_r),
    .sample(rd_data_r[15:8]), .median(v_med)
  );

  cmf_merge u_merge (
    .clk(clk), .rst_n(rst_n), .load(load), .u_med(u_med), .v_med(v_med),
    .last(last_r), .out_tready(out_tready), .out_tvalid(out_tvalid),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .slot_free(slot_free)
  );

`include "assert_macros.svh"
  `AST_IMPLY(a_load_free, load, (!out_tvalid || out_tready))
  `AST_IMPLY(a_drain_col, drain_r, (in_col_r == '0))
  `AST_NEXT(a_issue_flush, (rd_en && done_issue), (state_r == cmf_pkg::ST_FLUSH))
  `AST_IMPLY(a_busy_noacc, (state_r != cmf_pkg::ST_IDLE), !acc)
endmodule

@@ hdl/cmf_lane.sv @@
// One median lane: bitwise rank selection over repeated passes of the window.
// Depends on cmf_pkg.
module cmf_lane (
  input  logic                               clk,
  input  logic                               start,
  input  logic [cmf_pkg::CNT_W-1:0]          rank,
  input  cmf_pkg::cmf_tag_t                  tag,
  input  logic [cmf_pkg::SAMPLE_BITS-1:0]    sample,
  output logic [cmf_pkg::SAMPLE_BITS-1:0]    median
);
  logic [cmf_pkg::SAMPLE_BITS-1:0] prefix_r;
  logic [cmf_pkg::CNT_W-1:0]       k_r, cnt_r, cnt_nxt;
  logic [cmf_pkg::SAMPLE_BITS-1:0] hi_mask;
  logic                            match;

  always_comb begin
    hi_mask = {cmf_pkg::SAMPLE_BITS{1'b1}} << ({1'b0, tag.bitsel} + 4'd1);
    // sample agrees with the bits already fixed and has a zero at this bit
    match   = ((sample & hi_mask) == (prefix_r & hi_mask)) && !sample[tag.bitsel];
    cnt_nxt = (tag.first ? '0 : cnt_r) + cmf_pkg::CNT_W'(match);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prefix_r <= '0;
      k_r      <= rank;
      cnt_r    <= '0;
    end else if (tag.valid) begin
      cnt_r <= cnt_nxt;
      if (tag.last && !(k_r < cnt_nxt)) begin
        prefix_r[tag.bitsel] <= 1'b1;
        k_r                  <= k_r - cnt_nxt;
      end
    end
  end

  assign median = prefix_r;
endmodule

@@ hdl/cmf_merge.sv @@
// Output stage: joins the U and V lane results with the frame flag into one register.
// Depends on cmf_pkg.
module cmf_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [cmf_pkg::SAMPLE_BITS-1:0]      u_med,
  input  logic [cmf_pkg::SAMPLE_BITS-1:0]      v_med,
  input  logic                                 last,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [2*cmf_pkg::SAMPLE_BITS-1:0]    out_tdata, // u_out, v_out
  output logic                                 out_tlast, // frame_end
  output logic                                 slot_free
);
  logic                              valid_r;
  logic [2*cmf_pkg::SAMPLE_BITS-1:0] data_r;
  logic                              last_r;

  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {v_med, u_med};
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
endmodule
